// ----- rtl/fsq_pkg.sv -----
package fsq_pkg;

    localparam logic [31:0] SEED_MAGIC      = 32'h5F3759DF;
    localparam logic [31:0] FP_HALF         = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;
    localparam logic [31:0] CANON_NAN       = 32'h7FC00000;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } t_spec;

    function automatic logic fp_is_nan(input logic [31:0] v);
        fp_is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] v);
        fp_is_inf = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] v);
        fp_is_zero = (v[30:0] == 31'd0);
    endfunction

    // leading zeros of a 24-bit mantissa, 24 when empty
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(23 - i);
                found = 1'b1;
            end
        end
        lzc24 = n;
    endfunction

    // leading zeros of a 28-bit sum, 28 when empty
    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd28;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(27 - i);
                found = 1'b1;
            end
        end
        lzc28 = n;
    endfunction

endpackage

// ----- rtl/fast_sqrt_via_inverse_root.sv -----
// Approximate binary32 square root: a bit-trick seed for 1/sqrt(x), one Newton step
// ((0.5x*r)*r, 1.5 minus that, times r) and a final multiply by x, every operation
// rounded to nearest even with subnormals kept; NaN results leave as 0x7FC00000.
// One word is accepted per cycle unless a stall at the output has filled the pipe
// back to the input; each word passes 19 register stages (an input register, then
// five three-stage multipliers and one three-stage adder in a chain). Stages with no
// valid word absorb new input while the output is stalled, so a stall loses and
// repeats nothing.
module fast_sqrt_via_inverse_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value_bits
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] root_bits
);
    import fsq_pkg::*;

    localparam int NSTG = 19;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic [31:0]     r_xd [0:15];
    logic [31:0]     r_rd [0:12];
    logic [31:0]     h, t1, t2, u, r2, y;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_xd[0] <= i_s_tdata;
            r_rd[0] <= SEED_MAGIC - {i_s_tdata[31], i_s_tdata[31:1]};
        end
        for (int k = 1; k < 16; k++) begin
            if (en[k]) r_xd[k] <= r_xd[k-1];
        end
        for (int k = 1; k < 13; k++) begin
            if (en[k]) r_rd[k] <= r_rd[k-1];
        end
    end

    fsq_mul u_half (.i_clk(i_clk), .i_en(en[3:1]),   .i_a(r_xd[0]), .i_b(FP_HALF),
                    .o_p(h));
    fsq_mul u_hr   (.i_clk(i_clk), .i_en(en[6:4]),   .i_a(h),       .i_b(r_rd[3]),
                    .o_p(t1));
    fsq_mul u_hrr  (.i_clk(i_clk), .i_en(en[9:7]),   .i_a(t1),      .i_b(r_rd[6]),
                    .o_p(t2));
    fsq_add u_sub  (.i_clk(i_clk), .i_en(en[12:10]), .i_a(FP_THREE_HALVES),
                    .i_b({~t2[31], t2[30:0]}), .o_s(u));
    fsq_mul u_ru   (.i_clk(i_clk), .i_en(en[15:13]), .i_a(r_rd[12]), .i_b(u),
                    .o_p(r2));
    fsq_mul u_rx   (.i_clk(i_clk), .i_en(en[18:16]), .i_a(r2),       .i_b(r_xd[15]),
                    .o_p(y));

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = fp_is_nan(y) ? CANON_NAN : y;

endmodule

// ----- rtl/fsq_mul.sv -----
// binary32 multiply, round to nearest even, subnormals kept; three stages
module fsq_mul (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    import fsq_pkg::*;

    // exponent (signed, 10 bits) and normalised mantissa (24 bits)
    function automatic logic [33:0] unpack(input logic [31:0] v);
        logic [23:0]        ma;
        logic [4:0]         lz;
        logic signed [9:0]  e;
        ma = {|v[30:23], v[22:0]};
        lz = lzc24(ma);
        e  = ((v[30:23] == 8'd0) ? 10'sd1 : signed'({2'b00, v[30:23]}))
             - signed'({5'b00000, lz});
        unpack = {e, ma << lz};
    endfunction

    logic [33:0]        ua, ub;
    t_spec              n_spec;

    logic [23:0]        r_s1_ma, r_s1_mb;
    logic signed [9:0]  r_s1_ea, r_s1_eb;
    t_spec              r_s1_spec;

    logic [47:0]        r_s2_p;
    logic signed [10:0] r_s2_e;
    t_spec              r_s2_spec;

    logic [31:0]        r_s3_p;

    logic [47:0]        m, m2;
    logic signed [10:0] e;
    logic [6:0]         sh;
    logic               lost, inc;
    logic [7:0]         expf;
    logic [30:0]        mag;
    logic [31:0]        n_res;

    always_comb begin
        ua          = unpack(i_a);
        ub          = unpack(i_b);
        n_spec.nan  = fp_is_nan(i_a) || fp_is_nan(i_b)
                      || (fp_is_inf(i_a) && fp_is_zero(i_b))
                      || (fp_is_zero(i_a) && fp_is_inf(i_b));
        n_spec.inf  = fp_is_inf(i_a) || fp_is_inf(i_b);
        n_spec.zero = fp_is_zero(i_a) || fp_is_zero(i_b);
        n_spec.sign = i_a[31] ^ i_b[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_ma   <= ua[23:0];
            r_s1_mb   <= ub[23:0];
            r_s1_ea   <= signed'(ua[33:24]);
            r_s1_eb   <= signed'(ub[33:24]);
            r_s1_spec <= n_spec;
        end
        if (i_en[1]) begin
            r_s2_p    <= {24'd0, r_s1_ma} * {24'd0, r_s1_mb};
            r_s2_e    <= 11'(r_s1_ea) + 11'(r_s1_eb) - 11'sd127;
            r_s2_spec <= r_s1_spec;
        end
        if (i_en[2]) begin
            r_s3_p <= n_res;
        end
    end

    always_comb begin
        if (r_s2_p[47]) begin
            m = r_s2_p;
            e = r_s2_e + 11'sd1;
        end else begin
            m = r_s2_p << 1;
            e = r_s2_e;
        end
        // below the normal range: denormalise before rounding
        if (e >= 11'sd1)       sh = 7'd0;
        else if (e < -11'sd47) sh = 7'd48;
        else                   sh = 7'(11'sd1 - e);
        m2   = m >> sh;
        lost = |(m & ~({48{1'b1}} << sh));
        expf = (e >= 11'sd1) ? e[7:0] : 8'd0;
        inc  = m2[23] & ((|m2[22:0]) | lost | m2[24]);
        mag  = {expf, m2[46:24]} + {30'd0, inc};
        if (r_s2_spec.nan)
            n_res = CANON_NAN;
        else if (r_s2_spec.inf || e >= 11'sd255)
            n_res = {r_s2_spec.sign, 8'hFF, 23'd0};
        else if (r_s2_spec.zero)
            n_res = {r_s2_spec.sign, 31'd0};
        else
            n_res = {r_s2_spec.sign, mag};
    end

    assign o_p = r_s3_p;

endmodule

// ----- rtl/fsq_add.sv -----
// binary32 add, round to nearest even, subnormals kept; three stages
module fsq_add (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);
    import fsq_pkg::*;

    logic [31:0] big, lit;
    logic [7:0]  el, es, d;
    logic [23:0] ml, ms;
    logic [26:0] ext, al;
    t_spec       n_spec;

    logic [26:0] r_s1_ml, r_s1_al;
    logic [7:0]  r_s1_el;
    logic        r_s1_sub, r_s1_sign, r_s1_neg0;
    t_spec       r_s1_spec;

    logic [27:0] r_s2_sum;
    logic [4:0]  r_s2_lz;
    logic [7:0]  r_s2_el;
    logic        r_s2_sign, r_s2_neg0;
    t_spec       r_s2_spec;

    logic [31:0] r_s3_s;

    logic [27:0] n_sum;
    logic [26:0] nrm;
    logic [4:0]  s;
    logic [8:0]  e;
    logic [7:0]  expf;
    logic        inc;
    logic [30:0] mag;
    logic [31:0] n_res;

    always_comb begin
        if (i_a[30:0] >= i_b[30:0]) begin
            big = i_a;
            lit = i_b;
        end else begin
            big = i_b;
            lit = i_a;
        end
        el  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
        ml  = {|big[30:23], big[22:0]};
        ms  = {|lit[30:23], lit[22:0]};
        d   = el - es;
        ext = {ms, 3'b000};
        // align, folding shifted-out bits into sticky
        if (d >= 8'd27) begin
            al = {26'd0, |ms};
        end else begin
            al    = ext >> d;
            al[0] = al[0] | (|(ext & ~({27{1'b1}} << d)));
        end
        n_spec.nan  = fp_is_nan(i_a) || fp_is_nan(i_b)
                      || (fp_is_inf(i_a) && fp_is_inf(i_b) && (i_a[31] != i_b[31]));
        n_spec.inf  = fp_is_inf(i_a) || fp_is_inf(i_b);
        n_spec.zero = 1'b0;
        n_spec.sign = fp_is_inf(i_a) ? i_a[31] : i_b[31];
    end

    assign n_sum = r_s1_sub ? ({1'b0, r_s1_ml} - {1'b0, r_s1_al})
                            : ({1'b0, r_s1_ml} + {1'b0, r_s1_al});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_ml   <= {ml, 3'b000};
            r_s1_al   <= al;
            r_s1_el   <= el;
            r_s1_sub  <= i_a[31] ^ i_b[31];
            r_s1_sign <= big[31];
            r_s1_neg0 <= i_a[31] & i_b[31];
            r_s1_spec <= n_spec;
        end
        if (i_en[1]) begin
            r_s2_sum  <= n_sum;
            r_s2_lz   <= lzc28(n_sum);
            r_s2_el   <= r_s1_el;
            r_s2_sign <= r_s1_sign;
            r_s2_neg0 <= r_s1_neg0;
            r_s2_spec <= r_s1_spec;
        end
        if (i_en[2]) begin
            r_s3_s <= n_res;
        end
    end

    always_comb begin
        s = 5'd0;
        if (r_s2_lz == 5'd0) begin
            nrm = {r_s2_sum[27:2], r_s2_sum[1] | r_s2_sum[0]};
            e   = {1'b0, r_s2_el} + 9'd1;
        end else begin
            s = r_s2_lz - 5'd1;
            // stop at the subnormal boundary
            if ({3'b000, s} >= r_s2_el) s = 5'(r_s2_el - 8'd1);
            nrm = r_s2_sum[26:0] << s;
            e   = {1'b0, r_s2_el} - {4'b0000, s};
        end
        expf = nrm[26] ? e[7:0] : 8'd0;
        inc  = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
        mag  = {expf, nrm[25:3]} + {30'd0, inc};
        if (r_s2_spec.nan)
            n_res = CANON_NAN;
        else if (r_s2_spec.inf)
            n_res = {r_s2_spec.sign, 8'hFF, 23'd0};
        else if (r_s2_lz == 5'd28)
            n_res = {r_s2_neg0, 31'd0};
        else if (e >= 9'd255)
            n_res = {r_s2_sign, 8'hFF, 23'd0};
        else
            n_res = {r_s2_sign, mag};
    end

    assign o_s = r_s3_s;

endmodule

// ----- rtl/fsq_checker.sv -----
module fsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);
    import fsq_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed under stall");

    // a refused input word is offered again unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("input word changed while refused");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // an empty output stage means the whole pipe can advance
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input refused with empty output");

    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[30:23] == 8'hFF) && (o_m_tdata[22:0] != 23'd0)
        |-> o_m_tdata == CANON_NAN)
        else $error("non-canonical NaN");

endmodule

bind fast_sqrt_via_inverse_root fsq_checker u_fsq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
    .i_s_tdata(i_s_tdata), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata)
);
